### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the histogram RTL
// Concurrent checks clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mhd_pkg.sv
// ----------------------------------------------------------------------------
// mhd_pkg
// Types and constants of the mapped histogram with dithered rebinning.
// ----------------------------------------------------------------------------
package mhd_pkg;

    localparam int MAX_CHANNELS = 4096;
    localparam int CHAN_W       = $clog2(MAX_CHANNELS);
    localparam int PARAM_WIDTH  = 16;
    localparam int COUNT_WIDTH  = 32;
    localparam int NCH_W        = 13;
    localparam int SCALE_W      = 5;
    localparam int DITHER_W     = 7;
    localparam int RIDX_W       = 12;
    localparam int PROD_W       = PARAM_WIDTH + NCH_W;
    localparam int SPAN_W       = 32;
    localparam int CMP_W        = SPAN_W + DITHER_W;
    localparam int CLR_W        = CHAN_W + 1;
    localparam int DITHER_SPAN  = 100;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [NCH_W-1:0]   NCH_RESET   = NCH_W'(4096);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(12);

    // Configuration register indexes
    localparam logic CFG_IDX_CHANNELS = 1'b0;
    localparam logic CFG_IDX_SCALE    = 1'b1;

    // Operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_CHAN,
        ST_READ,
        ST_WB
    } mhd_state_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [CHAN_W-1:0] addr;
    } mhd_mem_req_t;

    typedef struct packed {
        logic              hit;
        logic [CHAN_W-1:0] chan;
    } mhd_map_res_t;

endpackage

### rtl/core/mhd_map.sv
// ----------------------------------------------------------------------------
// mhd_map
// Maps a raw parameter value to a channel: product, dithered rounding of the
// fraction and range check, over two register stages.
// ----------------------------------------------------------------------------
module mhd_map
    import mhd_pkg::*;
(
    input  logic                   clk,
    input  logic                   mul_en,
    input  logic                   chan_en,
    input  logic [PARAM_WIDTH-1:0] param_value,
    input  logic                   param_valid,
    input  logic [DITHER_W-1:0]    dither,
    input  logic [NCH_W-1:0]       channels_in_use,
    input  logic [SCALE_W-1:0]     param_scale_bits,
    output mhd_map_res_t           res
);

    logic [PROD_W-1:0] prod_reg;
    mhd_map_res_t      res_reg;
    mhd_map_res_t      res_next;

    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] frac;
    logic [CMP_W-1:0]  lhs;
    logic [CMP_W-1:0]  rhs;
    logic [PROD_W-1:0] quot;
    logic [PROD_W:0]   chan_wide;
    logic [NCH_W-1:0]  limit;
    logic              bump;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= PROD_W'(param_value) * PROD_W'(channels_in_use);
        end
        if (chan_en)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        span  = SPAN_W'(1) << param_scale_bits;
        frac  = SPAN_W'(prod_reg) & (span - SPAN_W'(1));
        quot  = prod_reg >> param_scale_bits;
        // bump when (1 - f) * 100 <= dither
        lhs   = CMP_W'(span - frac) * CMP_W'(DITHER_SPAN);
        rhs   = CMP_W'(dither) << param_scale_bits;
        bump  = (lhs <= rhs);
        chan_wide = (PROD_W + 1)'(quot) + (PROD_W + 1)'(bump);
        limit = (channels_in_use > NCH_W'(MAX_CHANNELS)) ? NCH_W'(MAX_CHANNELS)
                                                          : channels_in_use;
        res_next.hit  = param_valid && (chan_wide < (PROD_W + 1)'(limit));
        res_next.chan = chan_wide[CHAN_W-1:0];
    end

    assign res = res_reg;

endmodule

### rtl/core/mhd_store.sv
// ----------------------------------------------------------------------------
// mhd_store
// Counter memory: clearing sweep after reset, registered read and increment
// write-back of the entry last read.
// ----------------------------------------------------------------------------
module mhd_store
    import mhd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mhd_mem_req_t           req,
    output logic [COUNT_WIDTH-1:0] rd_data,
    output logic                   clear_busy
);

    logic [COUNT_WIDTH-1:0] mem [MAX_CHANNELS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [CLR_W-1:0]       clr_cnt_reg;

    assign clear_busy = !clr_cnt_reg[CHAN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clear_busy)
        begin
            clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy)
        begin
            mem[clr_cnt_reg[CHAN_W-1:0]] <= '0;
        end
        else if (req.wr_en)
        begin
            // wraps on overflow
            mem[req.addr] <= rd_data_reg + COUNT_WIDTH'(1);
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/mapped_histogram_dithered_unit.sv
// ----------------------------------------------------------------------------
// mapped_histogram_dithered_unit
// Histogram of wrapping counters with dithered mapping of raw values.
//
//   channel  dir  tdata (low bit up)                    tuser (low bit up)
//   s_axis   in   param_value, dither, read_index, pad  operation, param_valid
//   m_axis   out  hit_channel, read_count, pad          counted
//   cfg      in   cfg_we / cfg_index / cfg_wdata: 0 channels_in_use, 1 scale
//
// Each item passes multiply, channel select, memory read and increment
// write-back in turn before the next one is taken; read and write-back
// share the single port of the counter memory.
// After reset a clearing pass zeroes every counter; s_tready
// stays low meanwhile, configuration writes are taken.
// A result waits in the output register; the next item is taken meanwhile
// and holds in write-back until that register frees up.
// ----------------------------------------------------------------------------
module mapped_histogram_dithered_unit
    import mhd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // param_value, dither, read_index
    input  logic [1:0]           s_tuser,   // operation, param_valid
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // hit_channel, read_count
    output logic [0:0]           m_tuser,   // counted
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [NCH_W-1:0]     cfg_wdata
);

    mhd_state_t state_reg;
    mhd_state_t state_next;

    logic [NCH_W-1:0]   nch_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic                   op_reg;
    logic                   valid_reg;
    logic [PARAM_WIDTH-1:0] value_reg;
    logic [DITHER_W-1:0]    dither_reg;
    logic [RIDX_W-1:0]      ridx_reg;

    logic                   m_tvalid_reg;
    logic                   counted_reg;
    logic [CHAN_W-1:0]      hit_chan_reg;
    logic [COUNT_WIDTH-1:0] read_count_reg;

    logic                   s_xfer;
    logic                   out_free;
    logic                   out_load;
    logic                   mul_en;
    logic                   chan_en;
    logic                   clear_busy;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic [NCH_W-1:0]       chan_limit;
    mhd_mem_req_t           mem_req;
    mhd_map_res_t           map_res;

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nch_reg   <= NCH_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_CHANNELS: nch_reg   <= cfg_wdata;
                CFG_IDX_SCALE:    scale_reg <= cfg_wdata[SCALE_W-1:0];
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (!clear_busy) state_next = ST_IDLE;
            ST_IDLE:  if (s_xfer) state_next = ST_MUL;
            ST_MUL:   state_next = ST_CHAN;
            ST_CHAN:  state_next = ST_READ;
            ST_READ:  state_next = ST_WB;
            ST_WB:    if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_tready       = 1'b0;
        mul_en         = 1'b0;
        chan_en        = 1'b0;
        out_load       = 1'b0;
        mem_req.rd_en  = 1'b0;
        mem_req.wr_en  = 1'b0;
        mem_req.addr   = (op_reg == OP_READ) ? ridx_reg[CHAN_W-1:0] : map_res.chan;
        unique case (state_reg)
            ST_CLEAR: ;
            ST_IDLE:  s_tready = 1'b1;
            ST_MUL:   mul_en = 1'b1;
            ST_CHAN:  chan_en = 1'b1;
            ST_READ:  mem_req.rd_en = 1'b1;
            ST_WB:
            begin
                out_load      = out_free;
                mem_req.wr_en = out_free && (op_reg == OP_RECORD) && map_res.hit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Hold the item and the result payload
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            op_reg     <= s_tuser[0];
            valid_reg  <= s_tuser[1];
            value_reg  <= s_tdata[PARAM_WIDTH-1:0];
            dither_reg <= s_tdata[PARAM_WIDTH +: DITHER_W];
            ridx_reg   <= s_tdata[PARAM_WIDTH + DITHER_W +: RIDX_W];
        end
        if (out_load)
        begin
            counted_reg    <= (op_reg == OP_RECORD) && map_res.hit;
            hit_chan_reg   <= ((op_reg == OP_RECORD) && map_res.hit) ? map_res.chan : '0;
            read_count_reg <= (op_reg == OP_READ) ? rd_data : '0;
        end
    end

    mhd_map u_map (
        .clk              (clk),
        .mul_en           (mul_en),
        .chan_en          (chan_en),
        .param_value      (value_reg),
        .param_valid      (valid_reg),
        .dither           (dither_reg),
        .channels_in_use  (nch_reg),
        .param_scale_bits (scale_reg),
        .res              (map_res)
    );

    mhd_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (mem_req),
        .rd_data    (rd_data),
        .clear_busy (clear_busy)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = counted_reg;
    assign m_tdata  = {(M_TDATA_W - CHAN_W - COUNT_WIDTH)'(0), read_count_reg, hit_chan_reg};

    assign chan_limit = (nch_reg > NCH_W'(MAX_CHANNELS)) ? NCH_W'(MAX_CHANNELS) : nch_reg;

`include "assert_macros.svh"

    `ASSERT_NOW(a_no_xfer_in_clear, s_xfer, !clear_busy,
        "input transfer during clearing pass")
    `ASSERT_NOW(a_wr_after_read, mem_req.wr_en,
        ($past(state_reg) == ST_READ) || ($past(state_reg) == ST_WB),
        "counter write without a preceding read")
    `ASSERT_NOW(a_counted_in_range, m_tvalid_reg && counted_reg,
        NCH_W'(hit_chan_reg) < chan_limit, "counted channel beyond limit")
    `ASSERT_NEXT(a_single_write, mem_req.wr_en, !mem_req.wr_en,
        "counter written twice for one item")

endmodule
